// ----- sv/assert_macros.svh -----
// assertion macros for the rtl of the grid quantizer
// no dependencies; pulled in with an include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under clock and active-low reset
`define ETGQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("grid quantizer property violated");

// antecedent now implies consequent in the next cycle
`define ETGQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("grid quantizer next-cycle property violated");

`endif

// ----- sv/etgq_pkg.sv -----
// constants and register codes of the event time grid quantizer
// no dependencies; imported by event_time_grid_quantizer and the testbench
package etgq_pkg;

  // default widths
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned BEAT_BITS_DEF = 18;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_BEAT       = 3'd1,
    REG_RES        = 3'd2,
    REG_STRENGTH   = 3'd3,
    REG_SWING      = 3'd4,
    REG_MIN_CHANGE = 3'd5
  } cfg_reg_e;

  // reset values
  localparam logic        RST_ENABLE     = 1'b1;
  localparam int unsigned RST_BEAT       = 24000;
  localparam logic [2:0]  RST_RES        = 3'd3;
  localparam logic [8:0]  RST_STRENGTH   = 9'd205;
  localparam logic [8:0]  RST_SWING      = 9'd0;
  localparam logic [15:0] RST_MIN_CHANGE = 16'd48;

  // limits and fallbacks
  localparam int unsigned BEAT_MIN      = 16;
  localparam logic [2:0]  RES_MAX       = 3'd5;
  localparam logic [2:0]  RES_FALLBACK  = 3'd3;
  localparam logic [2:0]  RES_SWING_MIN = 3'd2;
  localparam logic [8:0]  STR_FULL      = 9'd256;
  localparam logic [8:0]  SWING_LIMIT   = 9'd128;

  // fixed point: grid held in 1/32 sample, beat scaled by 64 for a half note
  localparam int unsigned GRID_SHIFT = 6;
  localparam int unsigned FRAC_BITS  = 5;
  // swing offset is swing * g / 1280 = (swing * g / 256) / 5
  localparam int unsigned SWING_SHIFT = 8;
  // move = gap * strength / 8192, rounded half away from zero
  localparam int unsigned MOVE_SHIFT = 13;
  localparam int unsigned ROUND_BIAS = 4096;

endpackage

// ----- sv/event_time_grid_quantizer.sv -----
// A beat passes stage 0, the restoring divider, stages p1 to p4 and the output register.
// Throughput: one beat per cycle while the skid is empty; one quotient bit per stage.
// An output register and a one-entry skid buffer; the input stalls only while the skid is full.
// Reset clears configuration to its defaults and all stage valid bits; data regs are not reset.
// The swing offset is rebuilt from configuration via g32_q, swprod_q, swqm_q, off_mag_q.
// Depends on etgq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module event_time_grid_quantizer
  import etgq_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  parameter int unsigned BEAT_BITS = BEAT_BITS_DEF,
  localparam int unsigned CFG_W = (BEAT_BITS > 16) ? BEAT_BITS : 16,
  localparam int unsigned TDATA_W = ((TIME_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [TIME_BITS-1:0] event_time, zero fill above
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [TIME_BITS-1:0] adjusted_time, zero fill above
  output logic [0:0]         m_axis_tuser    // [0] moved
);

  // derived widths
  localparam int unsigned GW    = BEAT_BITS + GRID_SHIFT;        // grid spacing, 1/32 sample
  localparam int unsigned GMW   = GW + 1;                        // gap magnitude
  localparam int unsigned EW    = GW + 2;                        // signed distances
  localparam int unsigned PW    = GMW + 9;                       // gap times strength
  localparam int unsigned MW    = PW + 1 - MOVE_SHIFT;           // move in samples
  localparam int unsigned MCW   = (MW > 16) ? MW : 16;
  localparam int unsigned NW    = ((TIME_BITS > MW) ? TIME_BITS : MW) + 1;
  localparam int unsigned SWW   = GW - 1;                        // swing product over 256
  localparam int unsigned DIV_S = GW + 2;
  localparam logic [DIV_S-3:0] DIV_M = (DIV_S-2)'((64'd1 << DIV_S) / 5);
  localparam int unsigned NST   = TIME_BITS + 5;                 // stages before output
  localparam int unsigned ST_P4 = TIME_BITS + 4;

  // configuration registers
  logic                 enable_q;
  logic [BEAT_BITS-1:0] beat_q;
  logic [2:0]           res_q;
  logic [8:0]           strength_q;
  logic [8:0]           swing_q;
  logic [15:0]          min_change_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= RST_ENABLE;
      beat_q       <= BEAT_BITS'(RST_BEAT);
      res_q        <= RST_RES;
      strength_q   <= RST_STRENGTH;
      swing_q      <= RST_SWING;
      min_change_q <= RST_MIN_CHANGE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:     enable_q     <= cfg_wdata_i[0];
        REG_BEAT:       beat_q       <= cfg_wdata_i[BEAT_BITS-1:0];
        REG_RES:        res_q        <= cfg_wdata_i[2:0];
        REG_STRENGTH:   strength_q   <= cfg_wdata_i[8:0];
        REG_SWING:      swing_q      <= cfg_wdata_i[8:0];
        REG_MIN_CHANGE: min_change_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // clamped configuration values
  logic [BEAT_BITS-1:0] beat_eff;
  logic [2:0]           res_eff;
  logic [8:0]           str_eff;
  logic [8:0]           sw_abs9;
  logic [7:0]           sw_mag;
  logic                 sw_neg;
  logic                 swung;
  logic [GW-1:0]        g32_d;

  always_comb begin
    beat_eff = (beat_q < BEAT_BITS'(BEAT_MIN)) ? BEAT_BITS'(BEAT_MIN) : beat_q;
    res_eff  = (res_q > RES_MAX) ? RES_FALLBACK : res_q;
    str_eff  = (strength_q > STR_FULL) ? STR_FULL : strength_q;
    sw_neg   = swing_q[8];
    sw_abs9  = sw_neg ? (9'd0 - swing_q) : swing_q;
    sw_mag   = (sw_abs9 > SWING_LIMIT) ? SWING_LIMIT[7:0] : sw_abs9[7:0];
    swung    = (res_eff >= RES_SWING_MIN) && (sw_mag != 8'd0);
    g32_d    = {beat_eff, GRID_SHIFT'(0)} >> res_eff;
  end

  // grid spacing and swing offset, rebuilt every cycle from configuration
  logic [GW-1:0]          g32_q;
  logic [GW+7:0]          swprod_q;
  logic [SWW-1:0]         swy;
  logic [SWW-1:0]         swy_q;
  logic [SWW+DIV_S-3:0]   swqm_q;
  logic [SWW-1:0]         swq0;
  logic [SWW-1:0]         swr5;
  logic [SWW-1:0]         off_mag_q;
  logic signed [EW-1:0]   off_s;

  assign swy  = swprod_q[SWING_SHIFT +: SWW];
  assign swq0 = SWW'(swqm_q >> DIV_S);
  assign swr5 = swy_q - ((swq0 << 2) + swq0);

  always_ff @(posedge clk_i) begin
    g32_q     <= g32_d;
    swprod_q  <= (GW+8)'(sw_mag) * (GW+8)'(g32_q);
    swy_q     <= swy;
    swqm_q    <= (SWW+DIV_S-2)'(swy) * (SWW+DIV_S-2)'(DIV_M);
    off_mag_q <= (swr5 >= SWW'(5)) ? (swq0 + SWW'(1)) : swq0;
  end

  always_comb begin
    if (!swung) begin
      off_s = '0;
    end else if (sw_neg) begin
      off_s = -$signed(EW'(off_mag_q));
    end else begin
      off_s = $signed(EW'(off_mag_q));
    end
  end

  // pipeline advance: held only while the skid buffer is occupied
  logic           adv;
  logic           skid_v_q;
  logic [NST-1:0] vld_q;

  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // restoring divider: stage 0 captures, stages 1..TIME_BITS each add one quotient bit
  logic [TIME_BITS-1:0] t_q    [0:TIME_BITS];
  logic [GW-1:0]        rem_q  [0:TIME_BITS];
  logic [GW-1:0]        rem_nx [1:TIME_BITS];
  logic                 kodd_d;
  logic                 kodd_q;

  for (genvar j = 1; j <= TIME_BITS; j++) begin : g_div
    logic        nb;
    logic [GW:0] sh;
    logic        ge;
    // next dividend bit of event_time * 32, low five bits are zero
    if (j <= TIME_BITS - FRAC_BITS) begin : g_bit
      assign nb = t_q[j-1][TIME_BITS-FRAC_BITS-j];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign sh        = {rem_q[j-1], nb};
    assign ge        = (sh >= {1'b0, g32_q});
    assign rem_nx[j] = ge ? GW'(sh - {1'b0, g32_q}) : sh[GW-1:0];
    if (j == TIME_BITS) begin : g_last
      assign kodd_d = ge;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q[0]   <= s_axis_tdata[TIME_BITS-1:0];
      rem_q[0] <= GW'(s_axis_tdata[TIME_BITS-1 -: FRAC_BITS]);
      for (int unsigned j = 1; j <= TIME_BITS; j++) begin
        t_q[j]   <= t_q[j-1];
        rem_q[j] <= rem_nx[j];
      end
      kodd_q <= kodd_d;
    end
  end

  // stage p1: signed distances to the lower and upper grid points
  logic signed [EW-1:0]  off_a;
  logic signed [EW-1:0]  off_b;
  logic signed [EW-1:0]  ea_q;
  logic signed [EW-1:0]  eb_q;
  logic [TIME_BITS-1:0]  t1_q;

  assign off_a = kodd_q ? off_s : '0;
  assign off_b = kodd_q ? '0 : off_s;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ea_q <= $signed(EW'(rem_q[TIME_BITS])) - off_a;
      eb_q <= $signed(EW'(g32_q)) + off_b - $signed(EW'(rem_q[TIME_BITS]));
      t1_q <= t_q[TIME_BITS];
    end
  end

  // stage p2: pick the nearer point, ties to the earlier one
  logic [GMW-1:0]       da;
  logic [GMW-1:0]       db;
  logic                 pick_b;
  logic [GMW-1:0]       gmag_q;
  logic                 gneg_q;
  logic [TIME_BITS-1:0] t2_q;

  assign da     = ea_q[EW-1] ? GMW'(-ea_q) : GMW'(ea_q);
  assign db     = eb_q[EW-1] ? GMW'(-eb_q) : GMW'(eb_q);
  assign pick_b = (db < da);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gmag_q <= pick_b ? db : da;
      gneg_q <= pick_b ? eb_q[EW-1] : (ea_q > 0);
      t2_q   <= t1_q;
    end
  end

  // stage p3: scale the gap by strength
  logic [PW-1:0]        prod_q;
  logic                 gneg3_q;
  logic [TIME_BITS-1:0] t3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= PW'(gmag_q) * PW'(str_eff);
      gneg3_q <= gneg_q;
      t3_q    <= t2_q;
    end
  end

  // stage p4: round to whole samples and test against min_change
  logic [PW:0]          rounded;
  logic [MW-1:0]        mv_mag;
  logic [MW-1:0]        mag4_q;
  logic                 big4_q;
  logic                 neg4_q;
  logic [TIME_BITS-1:0] t4_q;

  assign rounded = (PW+1)'(prod_q) + (PW+1)'(ROUND_BIAS);
  assign mv_mag  = MW'(rounded >> MOVE_SHIFT);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag4_q <= mv_mag;
      big4_q <= (MCW'(mv_mag) > MCW'(min_change_q));
      neg4_q <= gneg3_q;
      t4_q   <= t3_q;
    end
  end

  // apply the move with saturation at both ends of the time range
  logic [NW-1:0]        tt;
  logic [NW-1:0]        mm;
  logic [NW-1:0]        sum;
  logic [TIME_BITS-1:0] nt;
  logic                 do_move;
  logic [TIME_BITS-1:0] res_t;

  always_comb begin
    tt  = NW'(t4_q);
    mm  = NW'(mag4_q);
    sum = tt + mm;
    if (neg4_q) begin
      nt = (mm > tt) ? '0 : TIME_BITS'(tt - mm);
    end else begin
      nt = (sum > NW'({TIME_BITS{1'b1}})) ? '1 : sum[TIME_BITS-1:0];
    end
    do_move = enable_q && (str_eff != 9'd0) && big4_q;
    res_t   = do_move ? nt : t4_q;
  end

  // output register with skid buffer
  logic                 in_beat;
  logic                 out_v_q;
  logic [TIME_BITS-1:0] out_t_q;
  logic                 out_mv_q;
  logic [TIME_BITS-1:0] skid_t_q;
  logic                 skid_mv_q;

  assign in_beat = adv && vld_q[ST_P4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_beat;
      end
    end else if (in_beat) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_t_q  <= skid_t_q;
        out_mv_q <= skid_mv_q;
      end else begin
        out_t_q  <= res_t;
        out_mv_q <= do_move;
      end
    end else if (in_beat) begin
      skid_t_q  <= res_t;
      skid_mv_q <= do_move;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = TDATA_W'(out_t_q);
  assign m_axis_tuser[0] = out_mv_q;

  // checks
  `ETGQ_ASSERT(a_rem_below_grid, clk_i, rst_ni, vld_q[TIME_BITS] |-> (rem_q[TIME_BITS] < g32_q))
  `ETGQ_ASSERT(a_moved_needs_enable, clk_i, rst_ni,
               (m_axis_tvalid && m_axis_tuser[0]) |-> (enable_q && (strength_q != 9'd0)))
  `ETGQ_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q)
  `ETGQ_ASSERT_NXT(a_last_stage_lands, clk_i, rst_ni, vld_q[ST_P4] && s_axis_tready, out_v_q)

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for event_time_grid_quantizer: directed corners, then random event times
// an in-bench model of the grid snap predicts each result; depends on etgq_pkg and the rtl top

module testbench
  import etgq_pkg::*;
();

  localparam int CFG_W          = 18;
  localparam int TDATA_W        = 32;
  localparam int LATENCY        = 37;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam longint TIME_TOP   = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] adj_time;
    logic        moved;
  } quant_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // [31:0] event_time
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;   // [31:0] adjusted_time
  logic [0:0]         m_axis_tuser;   // [0] moved

  // mirror of the register file as the block should hold it
  logic        cfg_enable;
  logic [17:0] cfg_beat;
  logic [2:0]  cfg_res;
  logic [8:0]  cfg_strength;
  logic [8:0]  cfg_swing;
  logic [15:0] cfg_min_change;

  quant_result_t pending_results[$];
  quant_result_t front_result;
  int errors       = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int quiet_cycles = 0;

  event_time_grid_quantizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // snap one event time toward the grid under the mirrored settings
  function automatic quant_result_t predict_quantized(logic [31:0] event_t);
    quant_result_t res;
    longint unsigned beat, g32, t32, k, mag;
    longint str, sw, off, tt, ts, a, b, da, db, target, gap, num, d, nt, minc;
    int unsigned r;
    bit swung;
    res.adj_time = event_t;
    res.moved    = 1'b0;
    str = (cfg_strength > STR_FULL) ? STR_FULL : cfg_strength;
    if (!cfg_enable || str == 0) return res;

    beat = (cfg_beat < BEAT_MIN) ? BEAT_MIN : cfg_beat;
    r    = (cfg_res > RES_MAX) ? RES_FALLBACK : cfg_res;
    sw   = $signed(cfg_swing);
    if (sw > 128) sw = 128;
    if (sw < -128) sw = -128;

    // grid spacing and time in 1/32 sample
    g32 = (beat << GRID_SHIFT) >> r;
    t32 = event_t;
    t32 = t32 << FRAC_BITS;
    ts  = t32;
    tt  = event_t;
    k   = t32 / g32;

    // odd points shift by swing, magnitude truncated
    swung = (r >= RES_SWING_MIN) && (sw != 0);
    off   = 0;
    if (swung) begin
      mag = (sw < 0) ? -sw : sw;
      mag = mag * g32 / 1280;
      off = (sw < 0) ? -longint'(mag) : longint'(mag);
    end

    // nearer candidate, tie to the earlier one
    a = k * g32;
    if (swung && k[0]) a = a + off;
    b = (k + 1) * g32;
    if (swung && !k[0]) b = b + off;
    da = ts - a;
    if (da < 0) da = -da;
    db = b - ts;
    if (db < 0) db = -db;
    target = (db < da) ? b : a;

    // scaled move, halves away from zero
    gap = target - ts;
    num = gap * str;
    mag = (num < 0) ? -num : num;
    mag = (mag + ROUND_BIAS) >> MOVE_SHIFT;
    d   = (num < 0) ? -longint'(mag) : longint'(mag);

    minc = cfg_min_change;
    if (((d < 0) ? -d : d) > minc) begin
      nt = tt + d;
      if (nt < 0) nt = 0;
      if (nt > TIME_TOP) nt = TIME_TOP;
      res.adj_time = nt[31:0];
      res.moved    = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  // offer one event beat and record its expected result once taken
  task automatic send_event(logic [31:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_quantized(t));
    @(negedge clk_i);
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // one register write; junk fills the unused upper data bits
  task automatic write_reg(cfg_reg_e idx, int unsigned value, bit junk);
    logic [CFG_W-1:0] data;
    data = junk ? CFG_W'($urandom) : CFG_W'(0);
    case (idx)
      REG_ENABLE: begin
        data[0] = value[0];
        cfg_enable = data[0];
      end
      REG_BEAT: begin
        data = value[17:0];
        cfg_beat = data;
      end
      REG_RES: begin
        data[2:0] = value[2:0];
        cfg_res = data[2:0];
      end
      REG_STRENGTH: begin
        data[8:0] = value[8:0];
        cfg_strength = data[8:0];
      end
      REG_SWING: begin
        data[8:0] = value[8:0];
        cfg_swing = data[8:0];
      end
      REG_MIN_CHANGE: begin
        data[15:0] = value[15:0];
        cfg_min_change = data[15:0];
      end
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // rewrite every register while idle, then let the swing offset settle
  task automatic apply_config(int en, int beat, int res, int str, int sw, int minc, bit junk);
    wait_idle();
    write_reg(REG_ENABLE, en, junk);
    write_reg(REG_BEAT, beat, junk);
    write_reg(REG_RES, res, junk);
    write_reg(REG_STRENGTH, str, junk);
    write_reg(REG_SWING, sw, junk);
    write_reg(REG_MIN_CHANGE, minc, junk);
    cfg_we_i <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // reset settings: sixteenth grid of 6000 samples
  task automatic test_reset_defaults();
    send_event(32'd0);
    send_event(32'd3000);        // exact midpoint, goes to the earlier point
    send_event(32'd6001);        // move below min_change
    send_event(32'd4500);
    send_event(32'hFFFF_FFFF);
  endtask

  task automatic test_passthrough();
    apply_config(0, 24000, 3, 205, 0, 48, 1'b0);
    send_event(32'd12345);
    send_event(32'hFFFF_FFFF);
    apply_config(1, 24000, 3, 0, 0, 48, 1'b0);
    send_event(32'd3000);
  endtask

  // every resolution code, swing set so it shows only at eighth and finer
  task automatic test_grid_settings();
    for (int r = 0; r < 8; r++) begin
      apply_config(1, 24000, r, 205, 64, 16, 1'b0);
      send_event(32'd1000003);
    end
  endtask

  // swing at and beyond its limits, and at -1, eighth grid of 12000 samples
  task automatic test_swing_limits();
    int codes[5] = '{128, -128, 200, -200, -1};
    foreach (codes[i]) begin
      apply_config(1, 24000, 2, 256, codes[i], 0, 1'b0);
      send_event(32'd17000);
    end
  endtask

  task automatic test_edge_values();
    // short beat counts as 16
    apply_config(1, 0, 0, 511, 0, 0, 1'b0);
    send_event(32'd20);
    apply_config(1, 15, 3, 300, 0, 0, 1'b0);
    send_event(32'd5);
    // longest beat with the largest threshold
    apply_config(1, 262143, 0, 256, 0, 65535, 1'b0);
    send_event(32'h8003_0D40);
    // move past the top of the time range saturates
    apply_config(1, 10000, 1, 256, 0, 48, 1'b0);
    send_event(32'hFFFF_FFFF);
    send_event(32'hFFFF_E000);
  endtask

  // hold the output for a long stretch so the pipe fills and stalls its input
  task automatic test_output_stall();
    apply_config(1, 24000, 3, 205, 40, 48, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 100; i++) send_event($urandom);
  endtask

  // random settings every 22 beats, times mostly near grid points
  task automatic test_random_stream(int n_items, int tx_pct, int rx_pct);
    longint unsigned g, k, t;
    int en, beat, res, str, sw, minc;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 22 == 0) begin
        en = ($urandom_range(9) != 0);
        case ($urandom_range(5))
          0:       beat = $urandom_range(15);
          1:       beat = $urandom_range(1000, 16);
          4:       beat = $urandom_range(262143);
          5:       beat = 262143;
          default: beat = $urandom_range(60000, 4000);
        endcase
        res = $urandom_range(7);
        case ($urandom_range(7))
          0:       str = 0;
          1:       str = $urandom_range(511, 257);
          2:       str = 256;
          default: str = $urandom_range(255, 1);
        endcase
        case ($urandom_range(3))
          0:       sw = 0;
          1:       sw = $urandom_range(511);
          default: sw = int'($urandom_range(256)) - 128;
        endcase
        case ($urandom_range(3))
          0:       minc = $urandom_range(65535);
          1:       minc = 0;
          default: minc = $urandom_range(200);
        endcase
        apply_config(en, beat, res, str, sw, minc, $urandom_range(1));
      end
      // grid spacing in whole samples, for aiming near points and midpoints
      g = (cfg_beat < BEAT_MIN) ? BEAT_MIN : cfg_beat;
      g = (g * 2) >> ((cfg_res > RES_MAX) ? RES_FALLBACK : cfg_res);
      k = $urandom_range(32'hFFFF_FFFF / g);
      case ($urandom_range(9))
        0, 1, 2: t = $urandom;
        3, 4:    t = k * g + g / 2;
        5:       t = k * g + g / 2 + $urandom_range(2) - 1;
        6, 7:    t = k * g + $urandom_range(64);
        default: t = k * g + $urandom_range(32'(g));
      endcase
      send_event(t[31:0]);
    end
  endtask

  // output side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      rx_hold_left  <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata, 0);
      end else begin
        front_result = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== front_result.adj_time)
          report_mismatch("adjusted_time", m_axis_tdata[31:0], front_result.adj_time);
        if (m_axis_tuser[0] !== front_result.moved)
          report_mismatch("moved", m_axis_tuser[0], front_result.moved);
      end
    end
  end

  // give up when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("event_time_grid_quantizer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_ENABLE;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_enable     = RST_ENABLE;
    cfg_beat       = 18'(RST_BEAT);
    cfg_res        = RST_RES;
    cfg_strength   = RST_STRENGTH;
    cfg_swing      = RST_SWING;
    cfg_min_change = RST_MIN_CHANGE;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 18;
    rx_idle_pct = 48;
    test_reset_defaults();
    test_passthrough();
    test_grid_settings();
    test_swing_limits();
    test_edge_values();
    test_output_stall();
    test_random_stream(110, 18, 48);
    test_random_stream(110, 48, 18);
    test_random_stream(110, 0, 0);

    wait_idle();
    repeat (2 * LATENCY) @(negedge clk_i);
    if (errors == 0) begin
      $display("event_time_grid_quantizer test passed");
    end else begin
      $display("event_time_grid_quantizer test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/etgq_pkg.sv
sv/event_time_grid_quantizer.sv
verif/testbench.sv
